/* sv/tlvp_pkg.sv */
// Package for the TLV stream parser: request/result payload structs,
// phase, kind and error code enums, and decode constants. No dependencies.
package tlvp_pkg;

  typedef enum logic [2:0] {
    PH_TAG1    = 3'd0,
    PH_TAG2    = 3'd1,
    PH_LEN1    = 3'd2,
    PH_LENHI   = 3'd3,
    PH_LENLO   = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_ZERO_TAG   = 2'd0,
    ERR_BAD_LENGTH = 2'd1,
    ERR_TRUNCATED  = 2'd2
  } err_t;

  localparam logic [7:0] LEN_LONG_ONE = 8'h81;
  localparam logic [7:0] LEN_LONG_TWO = 8'h82;
  localparam logic [3:0] TAG_EXT_NIBBLE = 4'hF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in_buffer;
  } tlvp_in_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] tag;
    logic [15:0] elem_length;
    logic [7:0]  payload_byte;
    logic        element_end;
    err_t        error_code;
  } tlvp_out_t;

endpackage

/* sv/tlvp_decode_core.sv */
// Decode core of the TLV stream parser: parse state registers plus the
// single-pass next-state and result logic for one buffer byte.
// Depends on tlvp_pkg.
module tlvp_decode_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  tlvp_pkg::tlvp_in_t  item,
  output logic              res_valid,
  output tlvp_pkg::tlvp_out_t res
);
  import tlvp_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] tag_acc, tag_acc_next;
  logic [15:0] length_acc, length_acc_next;
  logic [15:0] remaining, remaining_next;
  logic        discarding, discarding_next;

  logic [7:0]  b;
  logic        last;
  logic [15:0] hdr_len;
  logic [15:0] rem_dec;

  assign b    = item.data_byte;
  assign last = item.last_in_buffer;
  // Length that completes a header in this cycle (short form or low byte).
  assign hdr_len = (phase == PH_LEN1) ? {8'h00, b} : (length_acc | {8'h00, b});
  assign rem_dec = remaining - 16'd1;

  // Next state
  always_comb begin
    phase_next      = phase;
    tag_acc_next    = tag_acc;
    length_acc_next = length_acc;
    remaining_next  = remaining;
    discarding_next = discarding;
    if (step) begin
      if (discarding) begin
        if (last) begin
          discarding_next = 1'b0;
          phase_next      = PH_TAG1;
        end
      end else begin
        case (phase)
          PH_TAG2: begin
            tag_acc_next = tag_acc | {8'h00, b};
            phase_next   = last ? PH_TAG1 : PH_LEN1;
          end
          PH_LEN1: begin
            if (b[7] == 1'b0) begin
              length_acc_next = hdr_len;
              if (last) begin
                phase_next = PH_TAG1;
              end else begin
                remaining_next = hdr_len;
                phase_next     = (hdr_len == 16'd0) ? PH_TAG1 : PH_PAYLOAD;
              end
            end else if (b == LEN_LONG_ONE) begin
              length_acc_next = 16'd0;
              phase_next      = last ? PH_TAG1 : PH_LENLO;
            end else if (b == LEN_LONG_TWO) begin
              length_acc_next = 16'd0;
              phase_next      = last ? PH_TAG1 : PH_LENHI;
            end else begin
              phase_next      = PH_TAG1;
              discarding_next = !last;
            end
          end
          PH_LENHI: begin
            length_acc_next = {b, 8'h00};
            phase_next      = last ? PH_TAG1 : PH_LENLO;
          end
          PH_LENLO: begin
            length_acc_next = hdr_len;
            if (last) begin
              phase_next = PH_TAG1;
            end else begin
              remaining_next = hdr_len;
              phase_next     = (hdr_len == 16'd0) ? PH_TAG1 : PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            remaining_next = rem_dec;
            if (rem_dec == 16'd0 || last) begin
              phase_next = PH_TAG1;
            end
          end
          default: begin
            if (b == 8'h00) begin
              phase_next      = PH_TAG1;
              discarding_next = !last;
            end else if (b[3:0] == TAG_EXT_NIBBLE) begin
              tag_acc_next = {b, 8'h00};
              phase_next   = last ? PH_TAG1 : PH_TAG2;
            end else begin
              tag_acc_next = {8'h00, b};
              phase_next   = last ? PH_TAG1 : PH_LEN1;
            end
          end
        endcase
      end
    end
  end

  // Result
  always_comb begin
    res_valid        = 1'b0;
    res.kind         = KIND_ERROR;
    res.tag          = 16'd0;
    res.elem_length  = 16'd0;
    res.payload_byte = 8'h00;
    res.element_end  = 1'b0;
    res.error_code   = ERR_ZERO_TAG;
    if (step && !discarding) begin
      case (phase)
        PH_TAG2, PH_LENHI: begin
          if (last) begin
            res_valid      = 1'b1;
            res.error_code = ERR_TRUNCATED;
          end
        end
        PH_LEN1, PH_LENLO: begin
          if (phase == PH_LEN1 && b[7] == 1'b1) begin
            if (b == LEN_LONG_ONE || b == LEN_LONG_TWO) begin
              if (last) begin
                res_valid      = 1'b1;
                res.error_code = ERR_TRUNCATED;
              end
            end else begin
              res_valid      = 1'b1;
              res.error_code = ERR_BAD_LENGTH;
            end
          end else if (last) begin
            res_valid      = 1'b1;
            res.error_code = ERR_TRUNCATED;
          end else begin
            res_valid       = 1'b1;
            res.kind        = KIND_HEADER;
            res.tag         = tag_acc;
            res.elem_length = hdr_len;
            res.element_end = (hdr_len == 16'd0);
          end
        end
        PH_PAYLOAD: begin
          res_valid = 1'b1;
          if (rem_dec != 16'd0 && last) begin
            res.error_code = ERR_TRUNCATED;
          end else begin
            res.kind         = KIND_PAYLOAD;
            res.tag          = tag_acc;
            res.elem_length  = length_acc;
            res.payload_byte = b;
            res.element_end  = (rem_dec == 16'd0);
          end
        end
        default: begin
          if (b == 8'h00) begin
            res_valid      = 1'b1;
            res.error_code = ERR_ZERO_TAG;
          end else if (last) begin
            res_valid      = 1'b1;
            res.error_code = ERR_TRUNCATED;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TAG1;
      tag_acc    <= 16'd0;
      length_acc <= 16'd0;
      remaining  <= 16'd0;
      discarding <= 1'b0;
    end else begin
      phase      <= phase_next;
      tag_acc    <= tag_acc_next;
      length_acc <= length_acc_next;
      remaining  <= remaining_next;
      discarding <= discarding_next;
    end
  end

`ifndef NO_ASSERTIONS
  // Dropping bytes always happens from the first-tag phase.
  a_discard_phase: assert property (@(posedge clk) disable iff (rst)
    discarding |-> phase == PH_TAG1)
    else $error("discarding outside first tag phase");

  // Payload phase never holds a zero count.
  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> remaining != 16'd0)
    else $error("payload phase with nothing remaining");

  // A buffer end always returns the parser to a clean start.
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    step && last |=> phase == PH_TAG1 && !discarding)
    else $error("parser not restarted after buffer end");

  // Payload results only come from the payload phase.
  a_payload_src: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == KIND_PAYLOAD |-> phase == PH_PAYLOAD && !discarding)
    else $error("payload result outside payload phase");
`endif

endmodule

/* sv/tlv_stream_parser.sv */
// Top level of the TLV stream parser: request register, decode core and
// result register with valid/ready handshakes. Depends on tlvp_pkg and
// tlvp_decode_core.
//
// Decodes a BER-like TLV byte stream at one byte per clock. Each request is
// one buffer byte plus a flag that marks the buffer's last byte. A tag is one
// byte, or two when the first byte's low nibble is 0xF; a length is a short
// form below 0x80, or 0x81/0x82 followed by one or two big-endian bytes. Each
// completed header yields a header result, then each payload byte yields a
// payload result, the element's last one flagged by element_end (a
// zero-length header carries the flag itself). A zero tag byte, an unknown
// length form, or a buffer that ends inside an element (including a final
// zero-length element) gives a single error result; bytes are then dropped
// until the buffer ends. Many bytes give no result at all (tag and length
// bytes, dropped bytes). Throughput is one request per cycle as long as
// results are taken; each request is held in the request register, then its
// result in the result register, with the parse state updated in the single
// pass between them. A held result stalls the request register, and
// item_ready follows result_ready combinationally when both registers hold
// data.
module tlv_stream_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  tlvp_pkg::tlvp_in_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output tlvp_pkg::tlvp_out_t result
);
  import tlvp_pkg::*;

  tlvp_in_t  req_q;
  logic      req_valid;
  logic      advance;
  logic      step;
  logic      core_valid;
  tlvp_out_t core_res;

  // Result register is free when empty or being taken this cycle.
  assign advance    = !result_valid || result_ready;
  // Decode the held request only when its result, if any, has a place to go.
  assign step       = req_valid && advance;
  assign item_ready = !req_valid || advance;

  // Request register: hold one byte ahead of the decoder.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      req_valid <= 1'b1;
    end else if (step) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      req_q <= item;
    end
  end

  tlvp_decode_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (req_q),
    .res_valid (core_valid),
    .res       (core_res)
  );

  // Result register: load a fresh result, or drop the taken one.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= step && core_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && core_valid) begin
      result <= core_res;
    end
  end

endmodule
